// ===== hw/rtl/meq_pkg.sv =====
// Shared types and constants of the multi event queue engine.
// No dependencies.
package meq_pkg;

    localparam int NUM_QUEUES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int ID_W            = 31;
    localparam int MAXEV_W         = 7;
    localparam int NRES_W          = 5;
    localparam int TDATA_W         = 248;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_DELETE = 2'd1,
        OP_POST   = 2'd2,
        OP_WAIT   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NO_SLOT = 2'd2
    } status_t;

    typedef struct packed {
        logic [63:0]        ident;
        logic signed [15:0] filter;
        logic signed [63:0] data;
        logic [63:0]        udata;
    } evt_t;

    localparam int EVT_W = $bits(evt_t);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_FREE    = 7'b0000010,
        S_LOOK    = 7'b0000100,
        S_APPLY   = 7'b0001000,
        S_DEQ_RD  = 7'b0010000,
        S_DEQ_OUT = 7'b0100000,
        S_RESP    = 7'b1000000
    } fsm_t;

endpackage

// ===== hw/rtl/multi_event_queue_engine.sv =====
// Multi event queue engine: control sequencer, slot valid bits, output register.
// Depends on meq_pkg and meq_ram (slot table and event store).
//
// Usage: one command word enters on the s_ channel (s_tuser = operation).
// Create, delete and post give one result word; wait gives one word per
// dequeued event (up to 16) or one empty word, m_tlast marks the final one.
// One command at a time. Create scans the slot valid bits, one slot per
// cycle. Delete, post and wait look up the id through the slot table RAM
// at one slot per cycle, the RAM read being registered. A wait then reads
// the event store once per event, each read followed by output of its word.
// Results pass through one output register; the next command is taken
// while a result still waits there. If the receiver stalls, the engine
// holds its state until the register frees.
// Reset clears all slots and sets the id counter to one; event store
// contents need no clearing.
module multi_event_queue_engine
    import meq_pkg::*;
#(
    parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // queue_id, event_ident, event_filter, event_data, event_udata, max_events
    input  logic [TDATA_W-1:0] s_tdata,
    // operation
    input  logic [1:0]         s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // new_queue_id, out_event_ident, out_event_filter, out_event_data,
    // out_event_udata, delivered_count
    output logic [TDATA_W-1:0] m_tdata,
    // status, out_event_valid
    output logic [2:0]         m_tuser,
    output logic               m_tlast
);

    localparam int SW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int IW  = $clog2(NUM_QUEUES + 1);
    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int SLW = ID_W + PW + PW + CW;

    fsm_t                state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [ID_W-1:0]     qid_reg, qid_next;
    evt_t                evt_in_reg, evt_in_next;
    logic [MAXEV_W-1:0]  maxev_reg, maxev_next;
    logic [NUM_QUEUES-1:0] in_use_reg, in_use_next;
    logic [ID_W-1:0]     next_qid_reg, next_qid_next;
    logic [IW-1:0]       scan_reg, scan_next;
    logic [SW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [SW-1:0]       slot_reg, slot_next;
    logic [PW-1:0]       head_reg, head_next;
    logic [PW-1:0]       tail_reg, tail_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [NRES_W-1:0]   n_reg, n_next;
    logic [NRES_W-1:0]   k_reg, k_next;
    status_t             res_status_reg, res_status_next;
    logic [ID_W-1:0]     res_nid_reg, res_nid_next;

    logic                m_tvalid_reg, m_tvalid_next;
    status_t             out_status_reg, out_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [ID_W-1:0]     out_nid_reg, out_nid_next;
    evt_t                out_evt_reg, out_evt_next;
    logic [MAXEV_W-1:0]  out_cnt_reg, out_cnt_next;
    logic                out_last_reg, out_last_next;

    logic                slt_wr_en, slt_rd_en;
    logic [SW-1:0]       slt_wr_addr, slt_rd_addr;
    logic [SLW-1:0]      slt_wr_data, slt_rd_data;
    logic                evt_wr_en, evt_rd_en;
    logic [SW+PW-1:0]    evt_wr_addr, evt_rd_addr;
    evt_t                evt_wr_data, evt_rd_data;

    logic [ID_W-1:0]     rd_id;
    logic [PW-1:0]       rd_head, rd_tail;
    logic [CW-1:0]       rd_cnt;
    logic                out_free, hit, deq_last;
    logic [MAXEV_W-1:0]  cnt_ext, lim;
    logic [SW-1:0]       scan_idx;
    logic [PW-1:0]       tail_inc, head_inc;

    meq_ram #(.W(SLW), .AW(SW)) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (slt_wr_en),
        .wr_addr (slt_wr_addr),
        .wr_data (slt_wr_data),
        .rd_en   (slt_rd_en),
        .rd_addr (slt_rd_addr),
        .rd_data (slt_rd_data)
    );

    meq_ram #(.W(EVT_W), .AW(SW + PW)) u_evt_ram (
        .aclk    (aclk),
        .wr_en   (evt_wr_en),
        .wr_addr (evt_wr_addr),
        .wr_data (evt_wr_data),
        .rd_en   (evt_rd_en),
        .rd_addr (evt_rd_addr),
        .rd_data (evt_rd_data)
    );

    assign {rd_id, rd_head, rd_tail, rd_cnt} = slt_rd_data;
    assign out_free = !m_tvalid_reg || m_tready;
    assign hit      = cmp_vld_reg && in_use_reg[cmp_idx_reg] && (rd_id == qid_reg);
    assign deq_last = (k_reg == n_reg - NRES_W'(1));
    assign cnt_ext  = MAXEV_W'(cnt_reg);
    assign scan_idx = scan_reg[SW-1:0];
    assign tail_inc = (tail_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + PW'(1);
    assign head_inc = (head_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + PW'(1);

    always_comb begin
        lim = (cnt_ext < maxev_reg) ? cnt_ext : maxev_reg;
        if (lim > MAXEV_W'(MAX_RESULTS)) begin
            lim = MAXEV_W'(MAX_RESULTS);
        end
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        qid_next        = qid_reg;
        evt_in_next     = evt_in_reg;
        maxev_next      = maxev_reg;
        in_use_next     = in_use_reg;
        next_qid_next   = next_qid_reg;
        scan_next       = scan_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_vld_next    = cmp_vld_reg;
        slot_next       = slot_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cnt_next        = cnt_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        res_status_next = res_status_reg;
        res_nid_next    = res_nid_reg;

        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg;
        out_nid_next    = out_nid_reg;
        out_evt_next    = out_evt_reg;
        out_cnt_next    = out_cnt_reg;
        out_last_next   = out_last_reg;

        s_tready    = 1'b0;
        slt_wr_en   = 1'b0;
        slt_wr_addr = slot_reg;
        slt_wr_data = {qid_reg, head_reg, tail_reg, cnt_reg};
        slt_rd_en   = 1'b0;
        slt_rd_addr = scan_idx;
        evt_wr_en   = 1'b0;
        evt_wr_addr = {slot_reg, tail_reg};
        evt_wr_data = evt_in_reg;
        evt_rd_en   = 1'b0;
        evt_rd_addr = {slot_reg, head_reg};

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next            = op_t'(s_tuser);
                    qid_next           = s_tdata[30:0];
                    evt_in_next.ident  = s_tdata[94:31];
                    evt_in_next.filter = s_tdata[110:95];
                    evt_in_next.data   = s_tdata[174:111];
                    evt_in_next.udata  = s_tdata[238:175];
                    maxev_next         = s_tdata[245:239];
                    scan_next          = '0;
                    cmp_vld_next       = 1'b0;
                    res_nid_next       = '0;
                    if (op_t'(s_tuser) == OP_CREATE) begin
                        state_next = S_FREE;
                    end else if ((op_t'(s_tuser) == OP_WAIT && s_tdata[245:239] == '0)
                                 || s_tdata[30:0] == '0) begin
                        res_status_next = ST_INVALID;
                        state_next      = S_RESP;
                    end else begin
                        state_next = S_LOOK;
                    end
                end
            end
            S_FREE: begin
                if (!in_use_reg[scan_idx]) begin
                    slt_wr_en             = 1'b1;
                    slt_wr_addr           = scan_idx;
                    slt_wr_data           = {next_qid_reg, {(SLW - ID_W){1'b0}}};
                    in_use_next[scan_idx] = 1'b1;
                    res_status_next       = ST_OK;
                    res_nid_next          = next_qid_reg;
                    next_qid_next         = (next_qid_reg == '1) ? ID_W'(1)
                                                                 : next_qid_reg + ID_W'(1);
                    state_next            = S_RESP;
                end else if (scan_reg == IW'(NUM_QUEUES - 1)) begin
                    res_status_next = ST_NO_SLOT;
                    state_next      = S_RESP;
                end else begin
                    scan_next = scan_reg + IW'(1);
                end
            end
            S_LOOK: begin
                if (hit) begin
                    slot_next  = cmp_idx_reg;
                    head_next  = rd_head;
                    tail_next  = rd_tail;
                    cnt_next   = rd_cnt;
                    state_next = S_APPLY;
                end else if (scan_reg < IW'(NUM_QUEUES)) begin
                    slt_rd_en    = 1'b1;
                    cmp_idx_next = scan_idx;
                    cmp_vld_next = 1'b1;
                    scan_next    = scan_reg + IW'(1);
                end else begin
                    res_status_next = ST_INVALID;
                    state_next      = S_RESP;
                end
            end
            S_APPLY: begin
                res_status_next = ST_OK;
                state_next      = S_RESP;
                case (op_reg)
                    OP_DELETE: begin
                        in_use_next[slot_reg] = 1'b0;
                    end
                    OP_POST: begin
                        if (cnt_reg < CW'(QUEUE_DEPTH)) begin
                            evt_wr_en   = 1'b1;
                            slt_wr_en   = 1'b1;
                            slt_wr_data = {qid_reg, head_reg, tail_inc, cnt_reg + CW'(1)};
                        end
                    end
                    OP_WAIT: begin
                        if (lim != '0) begin
                            n_next     = NRES_W'(lim);
                            k_next     = '0;
                            state_next = S_DEQ_RD;
                        end
                    end
                    default: begin
                        res_status_next = ST_INVALID;
                    end
                endcase
            end
            S_DEQ_RD: begin
                evt_rd_en  = 1'b1;
                state_next = S_DEQ_OUT;
            end
            S_DEQ_OUT: begin
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = ST_OK;
                    out_valid_next  = 1'b1;
                    out_nid_next    = '0;
                    out_evt_next    = evt_rd_data;
                    out_cnt_next    = deq_last ? MAXEV_W'(n_reg) : '0;
                    out_last_next   = deq_last;
                    head_next       = head_inc;
                    cnt_next        = cnt_reg - CW'(1);
                    k_next          = k_reg + NRES_W'(1);
                    if (deq_last) begin
                        slt_wr_en   = 1'b1;
                        slt_wr_data = {qid_reg, head_inc, tail_reg, cnt_reg - CW'(1)};
                        state_next  = S_IDLE;
                    end else begin
                        state_next = S_DEQ_RD;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = res_status_reg;
                    out_valid_next  = 1'b0;
                    out_nid_next    = res_nid_reg;
                    out_evt_next    = '0;
                    out_cnt_next    = '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            in_use_reg   <= '0;
            next_qid_reg <= ID_W'(1);
            m_tvalid_reg <= 1'b0;
            cmp_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_use_reg   <= in_use_next;
            next_qid_reg <= next_qid_next;
            m_tvalid_reg <= m_tvalid_next;
            cmp_vld_reg  <= cmp_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        qid_reg        <= qid_next;
        evt_in_reg     <= evt_in_next;
        maxev_reg      <= maxev_next;
        scan_reg       <= scan_next;
        cmp_idx_reg    <= cmp_idx_next;
        slot_reg       <= slot_next;
        head_reg       <= head_next;
        tail_reg       <= tail_next;
        cnt_reg        <= cnt_next;
        n_reg          <= n_next;
        k_reg          <= k_next;
        res_status_reg <= res_status_next;
        res_nid_reg    <= res_nid_next;
        out_status_reg <= out_status_next;
        out_valid_reg  <= out_valid_next;
        out_nid_reg    <= out_nid_next;
        out_evt_reg    <= out_evt_next;
        out_cnt_reg    <= out_cnt_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_cnt_reg, out_evt_reg.udata, out_evt_reg.data,
                       out_evt_reg.filter, out_evt_reg.ident, out_nid_reg};
    assign m_tuser  = {out_valid_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

    a_qid_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        next_qid_reg != '0)
        else $error("id counter reached zero");

    a_mid_is_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[2])
        else $error("non-final result without event");

    a_deq_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DEQ_RD || state_reg == S_DEQ_OUT) |-> k_reg < n_reg)
        else $error("dequeue index past limit");

    a_deq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DEQ_OUT) |-> cnt_reg != '0)
        else $error("dequeue from empty queue");

endmodule

// ===== hw/rtl/meq_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module meq_ram #(
    parameter int W  = 8,
    parameter int AW = 4
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data
);

    logic [W-1:0] mem_reg [2**AW];
    logic [W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== verif/meq_checker.sv =====
// Result checker for the multi event queue engine: watches both stream channels,
// predicts result words from accepted command words, and counts mismatches.
// Depends on meq_pkg.
module meq_checker
    import meq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic [1:0]         s_tuser,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic [2:0]         m_tuser,
    input  logic               m_tlast,
    output int                 fail_count,
    output int                 pending,
    output int                 words_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NQ = NUM_QUEUES_DEF;
    localparam int DEPTH = QUEUE_DEPTH_DEF;

    typedef struct packed {
        logic [1:0]  status;
        logic [30:0] new_id;
        logic        ev_valid;
        logic [63:0] ident;
        logic [15:0] filter;
        logic [63:0] data;
        logic [63:0] udata;
        logic [6:0]  count;
        logic        last;
    } result_t;

    result_t expected_words[$];

    logic        q_used [NQ];
    logic [30:0] q_id   [NQ];
    int          q_head [NQ];
    int          q_tail [NQ];
    int          q_count[NQ];
    logic [30:0] id_counter;
    evt_t        evt_store[NQ*DEPTH];

    function automatic result_t plain(logic [1:0] st, logic [30:0] nid);
        result_t r;
        r = '0;
        r.status = st;
        r.new_id = nid;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic int find_queue(logic [30:0] id);
        if (id == 0) return -1;
        for (int i = 0; i < NQ; i++)
            if (q_used[i] && q_id[i] == id) return i;
        return -1;
    endfunction

    task automatic predict_command(op_t op, logic [TDATA_W-1:0] d);
        logic [30:0] id;
        logic [6:0]  maxev;
        evt_t        ev;
        result_t     r;
        int          s, n, e;
        id    = d[30:0];
        ev.ident  = d[94:31];
        ev.filter = d[110:95];
        ev.data   = d[174:111];
        ev.udata  = d[238:175];
        maxev = d[245:239];
        case (op)
            OP_CREATE: begin
                s = -1;
                for (int i = 0; i < NQ; i++)
                    if (!q_used[i] && s < 0) s = i;
                if (s < 0) begin
                    expected_words.push_back(plain(ST_NO_SLOT, '0));
                end else begin
                    q_used[s] = 1'b1;
                    q_id[s] = id_counter;
                    q_head[s] = 0;
                    q_tail[s] = 0;
                    q_count[s] = 0;
                    expected_words.push_back(plain(ST_OK, id_counter));
                    id_counter = (id_counter == 31'h7FFFFFFF) ? 31'd1 : id_counter + 1;
                end
            end
            OP_DELETE: begin
                s = find_queue(id);
                if (s < 0) expected_words.push_back(plain(ST_INVALID, '0));
                else begin
                    q_used[s] = 1'b0;
                    expected_words.push_back(plain(ST_OK, '0));
                end
            end
            OP_POST: begin
                s = find_queue(id);
                if (s < 0) expected_words.push_back(plain(ST_INVALID, '0));
                else begin
                    if (q_count[s] < DEPTH) begin
                        evt_store[s*DEPTH + q_tail[s]] = ev;
                        q_tail[s] = (q_tail[s] + 1) % DEPTH;
                        q_count[s]++;
                    end
                    expected_words.push_back(plain(ST_OK, '0));
                end
            end
            default: begin
                s = find_queue(id);
                if (maxev == 0 || s < 0) expected_words.push_back(plain(ST_INVALID, '0));
                else begin
                    n = q_count[s];
                    if (n > maxev) n = maxev;
                    if (n > MAX_RESULTS) n = MAX_RESULTS;
                    if (n == 0) expected_words.push_back(plain(ST_OK, '0));
                    for (int k = 0; k < n; k++) begin
                        e = s*DEPTH + q_head[s];
                        r = '0;
                        r.status = ST_OK;
                        r.ev_valid = 1'b1;
                        r.ident  = evt_store[e].ident;
                        r.filter = evt_store[e].filter;
                        r.data   = evt_store[e].data;
                        r.udata  = evt_store[e].udata;
                        r.last   = (k + 1 == n);
                        r.count  = (k + 1 == n) ? 7'(n) : 7'd0;
                        expected_words.push_back(r);
                        q_head[s] = (q_head[s] + 1) % DEPTH;
                        q_count[s]--;
                    end
                end
            end
        endcase
    endtask

    task automatic compare_word();
        result_t exp_r, got;
        got.new_id   = m_tdata[30:0];
        got.ident    = m_tdata[94:31];
        got.filter   = m_tdata[110:95];
        got.data     = m_tdata[174:111];
        got.udata    = m_tdata[238:175];
        got.count    = m_tdata[245:239];
        got.status   = m_tuser[1:0];
        got.ev_valid = m_tuser[2];
        got.last     = m_tlast;
        if (expected_words.size() == 0) begin
            $error("unexpected result word %h", got);
            fail_count++;
            return;
        end
        exp_r = expected_words.pop_front();
        if (got.status !== exp_r.status) begin
            $error("status: expected %0d got %0d", exp_r.status, got.status); fail_count++;
        end
        if (got.new_id !== exp_r.new_id) begin
            $error("new_queue_id: expected %0d got %0d", exp_r.new_id, got.new_id);
            fail_count++;
        end
        if (got.ev_valid !== exp_r.ev_valid) begin
            $error("out_event_valid: expected %0d got %0d", exp_r.ev_valid, got.ev_valid);
            fail_count++;
        end
        if (got.ident !== exp_r.ident) begin
            $error("out_event_ident: expected %h got %h", exp_r.ident, got.ident);
            fail_count++;
        end
        if (got.filter !== exp_r.filter) begin
            $error("out_event_filter: expected %h got %h", exp_r.filter, got.filter);
            fail_count++;
        end
        if (got.data !== exp_r.data) begin
            $error("out_event_data: expected %h got %h", exp_r.data, got.data);
            fail_count++;
        end
        if (got.udata !== exp_r.udata) begin
            $error("out_event_udata: expected %h got %h", exp_r.udata, got.udata);
            fail_count++;
        end
        if (got.count !== exp_r.count) begin
            $error("delivered_count: expected %0d got %0d", exp_r.count, got.count);
            fail_count++;
        end
        if (got.last !== exp_r.last) begin
            $error("last: expected %0d got %0d", exp_r.last, got.last); fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        words_seen = 0;
        pending = 0;
        id_counter = 31'd1;
        for (int i = 0; i < NQ; i++) begin
            q_used[i] = 0; q_id[i] = 0; q_head[i] = 0; q_tail[i] = 0; q_count[i] = 0;
        end
    end

    // input side first so a result in the same cycle as its command would still find its expectation
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_command(op_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready) begin
                compare_word();
                words_seen++;
            end
            pending = expected_words.size();
        end
    end
endmodule

// ===== verif/tb.sv =====
// Top of the multi event queue engine testbench: clock, reset, command stimulus
// with random idling, verdict. Depends on meq_pkg, meq_checker and the engine RTL.
module tb;
    import meq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;  // queue_id, event_ident/filter/data/udata, max_events
    logic [1:0]         s_tuser;  // operation
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;  // new_queue_id, out_event fields, delivered_count
    logic [2:0]         m_tuser;  // status, out_event_valid
    logic               m_tlast;

    int fail_count, pending, words_seen;
    int send_idle_pct, recv_stall_pct;
    int idle_cycles;
    int commands_sent;
    bit timed_out;
    logic [30:0] live_ids[$];
    logic [30:0] last_new_id;

    multi_event_queue_engine dut (.*);

    meq_checker checker_i (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .fail_count, .pending, .words_seen
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog: no traffic for %0d cycles", WATCHDOG);
            $display("FAILURE");
            $finish;
        end
    end

    // track created ids from result words so the stimulus targets live queues
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready && m_tuser[1:0] == ST_OK && m_tdata[30:0] != 0)
            live_ids.push_back(m_tdata[30:0]);
    end

    task automatic send(op_t op, logic [30:0] id, logic [6:0] maxev, bit ext);
        logic [TDATA_W-1:0] d;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        d = '0;
        d[30:0]    = id;
        d[94:31]   = ext ? {64{$urandom_range(1)==1'b1}} : {$urandom, $urandom};
        d[110:95]  = ext ? {16{$urandom_range(1)==1'b1}} : 16'($urandom);
        d[174:111] = ext ? {1'b1, 63'd0} : {$urandom, $urandom};
        d[238:175] = {$urandom, $urandom};
        d[245:239] = maxev;
        s_tdata  <= d;
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        commands_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [30:0] pick_id();
        int r;
        r = $urandom_range(99);
        if (live_ids.size() == 0 || r < 8) return (r < 3) ? 31'd0 : 31'($urandom);
        return live_ids[$urandom_range(live_ids.size() - 1)];
    endfunction

    task automatic random_phase(int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 8 || live_ids.size() == 0) send(OP_CREATE, 31'($urandom), 7'($urandom), 0);
            else if (r < 13) send(OP_DELETE, pick_id(), 7'($urandom), 0);
            else if (r < 62) send(OP_POST, pick_id(), 7'($urandom), $urandom_range(9) == 0);
            else send(OP_WAIT, pick_id(),
                      ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(20)), 0);
            drain();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_CREATE;
        m_tready = 1'b0;
        idle_cycles = 0;
        commands_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, full table, full queue, zero and large waits
        send(OP_DELETE, 31'd0, 7'd1, 0);
        send(OP_POST, 31'h7FFFFFFF, 7'd1, 1);
        send(OP_WAIT, 31'd5, 7'd0, 0);
        drain();
        for (int i = 0; i < 9; i++) send(OP_CREATE, 31'($urandom), 7'd0, 0);
        drain();
        send(OP_WAIT, 31'd1, 7'd64, 0);
        for (int i = 0; i < 18; i++) send(OP_POST, 31'd1, 7'd0, i[0]);
        drain();
        send(OP_WAIT, 31'd1, 7'd0, 0);
        send(OP_WAIT, 31'd1, 7'd127, 0);
        send(OP_WAIT, 31'd1, 7'd3, 0);
        send(OP_DELETE, 31'd2, 7'd0, 0);
        send(OP_CREATE, 31'd0, 7'd0, 0);
        drain();
        live_ids.delete();
        for (int i = 0; i < 8; i++) begin
            send(OP_DELETE, 31'(i + 1), 7'd0, 0);
            send(OP_DELETE, 31'(10), 7'd0, 0);
        end
        drain();

        send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(95);
        send_idle_pct = 82; recv_stall_pct = 0;  random_phase(95);
        send_idle_pct = 0;  recv_stall_pct = 82; random_phase(90);
        send_idle_pct = 9;  recv_stall_pct = 9;  random_phase(90);
        recv_stall_pct = 0;
        drain();
        repeat (40) @(posedge aclk);

        $display("Ran %0d commands over create/delete/post/wait, %0d result words checked,",
                 commands_sent, words_seen);
        $display("covering full table, full queues, bad ids, zero and oversized waits.");
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
